FILE: hw/rtl/psmpd_pkg.sv
// shared types and constants for the planar point set diameter block
`timescale 1ns / 1ps

package psmpd_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned DistW  = 17;
  localparam int unsigned KeptW  = 11;
  localparam int unsigned SqW    = 34;
  localparam int unsigned AbsW   = 16;
  localparam int unsigned EntryW = 2 * CoordW;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic                     last_point;
  } in_req_t;

  typedef struct packed {
    logic [DistW-1:0] max_distance;
    logic [KeptW-1:0] points_kept;
    logic             overflowed;
  } out_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_ROOT_GO,
    ST_ROOT,
    ST_RESULT
  } psmpd_state_e;

endpackage

FILE: hw/rtl/point_set_max_planar_distance_top.sv
// top level: point set planar diameter, controller and output register
//
// usage
//   input channel: in_valid_i / in_stall_o carry one point per request
//   (x, y in signed mm, last_point marks the end of a set)
//   output channel: out_valid_o / out_stall_i carry one result per set,
//   issued only for a request with last_point set
//   a kept point is compared with every stored point of the set, one stored point
//   per cycle read from the point store memory; the scan covers the n >= 1
//   points already stored (at most MAX_POINTS - 1), there is no scan when the
//   set is empty or the store is full, and the last point of a set also runs
//   the bit-serial square root
//   in_stall_o is high while a request is in work
//   the result sits in an output register; a stall on the output holds it
//   and the next set may be taken meanwhile, only a second result waits
//   reset clears the point count, the maximum and the overflow flag; the
//   store contents need no clearing, so the block is ready right after reset
//   points past MAX_POINTS in one set are dropped and flagged
`timescale 1ns / 1ps

module point_set_max_planar_distance_top #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  psmpd_pkg::in_req_t  in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output psmpd_pkg::out_rsp_t out_rsp_o
);

  localparam int unsigned IdxW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_POINTS);

  psmpd_pkg::psmpd_state_e state_d, state_q;

  logic signed [psmpd_pkg::CoordW-1:0] px_d, px_q, py_d, py_q;
  logic last_d, last_q;
  logic [CntW-1:0] count_d, count_q, count_m1;
  logic ovf_d, ovf_q;
  logic [IdxW-1:0] rd_addr_d, rd_addr_q, scan_end_d, scan_end_q;
  logic rd_en, rd_vld_q;
  logic wr_en;
  logic in_acc, out_acc;
  logic clear_set, root_start, root_done;
  logic dist_busy;
  logic [psmpd_pkg::SqW-1:0] best;
  logic [psmpd_pkg::DistW-1:0] root;
  logic [psmpd_pkg::EntryW-1:0] rd_data;
  logic out_valid_d, out_valid_q;
  psmpd_pkg::out_rsp_t out_d, out_q;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_q && !out_stall_i;
  assign count_m1 = count_q - 1'b1;

  always_comb begin
    state_d     = state_q;
    px_d        = px_q;
    py_d        = py_q;
    last_d      = last_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    rd_addr_d   = rd_addr_q;
    scan_end_d  = scan_end_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    clear_set   = 1'b0;
    root_start  = 1'b0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && !out_acc;
    out_d       = out_q;
    case (state_q)
      psmpd_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          px_d   = in_req_i.point_x;
          py_d   = in_req_i.point_y;
          last_d = in_req_i.last_point;
          if (count_q < MaxCnt) begin
            wr_en      = 1'b1;
            count_d    = count_q + 1'b1;
            rd_addr_d  = '0;
            scan_end_d = count_m1[IdxW-1:0];
            if (count_q != '0) begin
              state_d = psmpd_pkg::ST_SCAN;
            end else if (in_req_i.last_point) begin
              state_d = psmpd_pkg::ST_ROOT_GO;
            end
          end else begin
            ovf_d = 1'b1;
            if (in_req_i.last_point) begin
              state_d = psmpd_pkg::ST_ROOT_GO;
            end
          end
        end
      end
      psmpd_pkg::ST_SCAN: begin
        rd_en     = 1'b1;
        rd_addr_d = rd_addr_q + 1'b1;
        if (rd_addr_q == scan_end_q) begin
          state_d = psmpd_pkg::ST_DRAIN;
        end
      end
      psmpd_pkg::ST_DRAIN: begin
        if (!dist_busy) begin
          state_d = last_q ? psmpd_pkg::ST_ROOT_GO : psmpd_pkg::ST_IDLE;
        end
      end
      psmpd_pkg::ST_ROOT_GO: begin
        root_start = 1'b1;
        state_d    = psmpd_pkg::ST_ROOT;
      end
      psmpd_pkg::ST_ROOT: begin
        if (root_done) begin
          state_d = psmpd_pkg::ST_RESULT;
        end
      end
      psmpd_pkg::ST_RESULT: begin
        if (!out_valid_q || out_acc) begin
          out_valid_d          = 1'b1;
          out_d.max_distance   = root;
          out_d.points_kept    = psmpd_pkg::KeptW'(count_q);
          out_d.overflowed     = ovf_q;
          clear_set            = 1'b1;
          count_d              = '0;
          ovf_d                = 1'b0;
          state_d              = psmpd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = psmpd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psmpd_pkg::ST_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      rd_vld_q    <= rd_en;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q       <= px_d;
    py_q       <= py_d;
    last_q     <= last_d;
    rd_addr_q  <= rd_addr_d;
    scan_end_q <= scan_end_d;
    out_q      <= out_d;
  end

  psmpd_store #(
    .Depth (MAX_POINTS)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[IdxW-1:0]),
    .wr_data_i ({in_req_i.point_y, in_req_i.point_x}),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr_q),
    .rd_data_o (rd_data)
  );

  psmpd_dist u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (clear_set),
    .ref_x_i    (px_q),
    .ref_y_i    (py_q),
    .data_vld_i (rd_vld_q),
    .data_i     (rd_data),
    .busy_o     (dist_busy),
    .best_o     (best)
  );

  psmpd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .value_i (best),
    .done_o  (root_done),
    .root_o  (root)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt)
    else $error("point count beyond capacity");

  a_read_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (CntW'(rd_addr_q) < count_q))
    else $error("read of a store entry not yet written in this set");

  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (in_acc && (count_q < MaxCnt)))
    else $error("store write without an accepted request or room");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == psmpd_pkg::ST_RESULT))
    else $error("result issued outside the result step");
`endif

endmodule

FILE: hw/rtl/psmpd_store.sv
// point store memory, one write port and one registered read port
`timescale 1ns / 1ps

module psmpd_store #(
  parameter int unsigned Depth = 1024,
  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [IdxW-1:0]              wr_addr_i,
  input  logic [psmpd_pkg::EntryW-1:0] wr_data_i,
  input  logic                         rd_en_i,
  input  logic [IdxW-1:0]              rd_addr_i,
  output logic [psmpd_pkg::EntryW-1:0] rd_data_o
);

  logic [psmpd_pkg::EntryW-1:0] mem_q [Depth];
  logic [psmpd_pkg::EntryW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hw/rtl/psmpd_dist.sv
// squared distance pipeline and running maximum
`timescale 1ns / 1ps

module psmpd_dist (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                clear_i,
  input  logic signed [psmpd_pkg::CoordW-1:0] ref_x_i,
  input  logic signed [psmpd_pkg::CoordW-1:0] ref_y_i,
  input  logic                                data_vld_i,
  input  logic [psmpd_pkg::EntryW-1:0]        data_i,
  output logic                                busy_o,
  output logic [psmpd_pkg::SqW-1:0]           best_o
);

  localparam int unsigned DiffW = psmpd_pkg::CoordW + 1;
  localparam int unsigned ProdW = 2 * psmpd_pkg::AbsW;

  logic [DiffW-1:0] dx, dy, neg_dx, neg_dy;
  logic [psmpd_pkg::AbsW-1:0] ax_d, ay_d, ax_q, ay_q;
  logic [ProdW-1:0] sqx_q, sqy_q;
  logic [ProdW:0] sum;
  logic v1_q, v2_q;
  logic [psmpd_pkg::SqW-1:0] best_d, best_q;

  always_comb begin
    dx = {ref_x_i[psmpd_pkg::CoordW-1], ref_x_i}
       - {data_i[psmpd_pkg::CoordW-1], data_i[psmpd_pkg::CoordW-1:0]};
    dy = {ref_y_i[psmpd_pkg::CoordW-1], ref_y_i}
       - {data_i[psmpd_pkg::EntryW-1], data_i[psmpd_pkg::EntryW-1:psmpd_pkg::CoordW]};
    neg_dx = -dx;
    neg_dy = -dy;
    ax_d = dx[DiffW-1] ? neg_dx[psmpd_pkg::AbsW-1:0] : dx[psmpd_pkg::AbsW-1:0];
    ay_d = dy[DiffW-1] ? neg_dy[psmpd_pkg::AbsW-1:0] : dy[psmpd_pkg::AbsW-1:0];
    sum = {1'b0, sqx_q} + {1'b0, sqy_q};
    best_d = best_q;
    if (clear_i) begin
      best_d = '0;
    end else if (v2_q && (psmpd_pkg::SqW'(sum) > best_q)) begin
      best_d = psmpd_pkg::SqW'(sum);
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q  <= ax_d;
    ay_q  <= ay_d;
    sqx_q <= ax_q * ax_q;
    sqy_q <= ay_q * ay_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      best_q <= '0;
    end else begin
      v1_q   <= data_vld_i;
      v2_q   <= v1_q;
      best_q <= best_d;
    end
  end

  assign busy_o = data_vld_i | v1_q | v2_q;
  assign best_o = best_q;

endmodule

FILE: hw/rtl/psmpd_isqrt.sv
// iterative integer square root, one result bit per cycle
`timescale 1ns / 1ps

module psmpd_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [psmpd_pkg::SqW-1:0]    value_i,
  output logic                         done_o,
  output logic [psmpd_pkg::DistW-1:0]  root_o
);

  localparam int unsigned RemW = psmpd_pkg::DistW + 3;
  localparam int unsigned CntW = $clog2(psmpd_pkg::DistW);
  localparam logic [CntW-1:0] LastStep = CntW'(psmpd_pkg::DistW - 1);

  logic [psmpd_pkg::SqW-1:0]   val_d, val_q;
  logic [RemW-1:0]             rem_d, rem_q, rem_sh, trial;
  logic [psmpd_pkg::DistW-1:0] root_d, root_q;
  logic [CntW-1:0]             cnt_d, cnt_q;
  logic                        busy_d, busy_q, done_d, done_q;

  always_comb begin
    val_d  = val_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_sh = {rem_q[RemW-3:0], val_q[psmpd_pkg::SqW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    if (start_i) begin
      val_d  = value_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = LastStep;
      busy_d = 1'b1;
    end else if (busy_q) begin
      val_d = {val_q[psmpd_pkg::SqW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[psmpd_pkg::DistW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[psmpd_pkg::DistW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    cnt_q  <= cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: dv/point_set_max_planar_distance_top_tb.sv
// testbench for the point set planar diameter block: directed table, random sets, scoreboard
`timescale 1ns / 1ps

module point_set_max_planar_distance_top_tb;

  localparam int unsigned MaxPoints = 1024;
  localparam int unsigned RandItems = 565;
  localparam int unsigned NumRows   = 15;
  localparam int unsigned DrainWait = 40;

  typedef struct packed {
    logic signed [psmpd_pkg::CoordW-1:0] x;
    logic signed [psmpd_pkg::CoordW-1:0] y;
    logic                                last;
    logic                                typed;
    logic [psmpd_pkg::DistW-1:0]         max_dist;
    logic [psmpd_pkg::KeptW-1:0]         kept;
    logic                                ovf;
  } dir_row_t;

  localparam dir_row_t DirRows [NumRows] = '{
    '{16'sh8000, 16'sh7fff, 1'b1, 1'b1, 17'd0,     11'd1, 1'b0},
    '{16'sh8000, 16'sh8000, 1'b0, 1'b0, 17'd0,     11'd0, 1'b0},
    '{16'sh7fff, 16'sh7fff, 1'b1, 1'b1, 17'd92680, 11'd2, 1'b0},
    '{16'sh0000, 16'sh0000, 1'b0, 1'b0, 17'd0,     11'd0, 1'b0},
    '{16'sh7fff, 16'sh0000, 1'b0, 1'b0, 17'd0,     11'd0, 1'b0},
    '{16'sh8000, 16'sh0000, 1'b1, 1'b1, 17'd65535, 11'd3, 1'b0},
    '{16'sh0000, 16'sh8000, 1'b0, 1'b0, 17'd0,     11'd0, 1'b0},
    '{16'sh0000, 16'sh7fff, 1'b1, 1'b1, 17'd65535, 11'd2, 1'b0},
    '{16'sd100,  16'sd100,  1'b0, 1'b0, 17'd0,     11'd0, 1'b0},
    '{16'sd100,  16'sd100,  1'b1, 1'b1, 17'd0,     11'd2, 1'b0},
    '{16'sd0,    16'sd0,    1'b0, 1'b0, 17'd0,     11'd0, 1'b0},
    '{16'sd3,    16'sd4,    1'b1, 1'b1, 17'd5,     11'd2, 1'b0},
    '{16'sd1234, -16'sd567, 1'b0, 1'b0, 17'd0,     11'd0, 1'b0},
    '{-16'sd20000, 16'sd1,  1'b0, 1'b0, 17'd0,     11'd0, 1'b0},
    '{16'sd31000, -16'sd31000, 1'b1, 1'b0, 17'd0,  11'd0, 1'b0}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  psmpd_pkg::in_req_t  in_req_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  psmpd_pkg::out_rsp_t out_rsp_o;

  logic signed [psmpd_pkg::CoordW-1:0] kept_x [MaxPoints];
  logic signed [psmpd_pkg::CoordW-1:0] kept_y [MaxPoints];
  int unsigned                         kept_count;
  longint unsigned                     best_sq;
  bit                                  dropped;

  psmpd_pkg::out_rsp_t pending_diameters [$];
  int unsigned mismatches;
  bit calm;
  int unsigned stall_left = 0;

  point_set_max_planar_distance_top #(
    .MAX_POINTS(MaxPoints)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #40000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [psmpd_pkg::DistW-1:0] floor_sqrt(input longint unsigned v);
    logic [psmpd_pkg::DistW-1:0] root;
    logic [psmpd_pkg::DistW-1:0] trial;
    longint unsigned             t;
    root = '0;
    for (int b = psmpd_pkg::DistW - 1; b >= 0; b--) begin
      trial = root | (17'd1 << b);
      t = trial;
      if (t * t <= v) root = trial;
    end
    return root;
  endfunction

  function automatic bit diameter_step(input psmpd_pkg::in_req_t r,
                                       output psmpd_pkg::out_rsp_t rsp);
    longint          dx;
    longint          dy;
    longint unsigned sq;
    rsp = '0;
    if (kept_count < MaxPoints) begin
      for (int unsigned k = 0; k < kept_count; k++) begin
        dx = longint'(r.point_x) - longint'(kept_x[k]);
        dy = longint'(r.point_y) - longint'(kept_y[k]);
        sq = dx * dx + dy * dy;
        if (sq > best_sq) best_sq = sq;
      end
      kept_x[kept_count] = r.point_x;
      kept_y[kept_count] = r.point_y;
      kept_count++;
    end else begin
      dropped = 1'b1;
    end
    if (!r.last_point) return 1'b0;
    rsp.max_distance = floor_sqrt(best_sq);
    rsp.points_kept  = kept_count[psmpd_pkg::KeptW-1:0];
    rsp.overflowed   = dropped;
    kept_count = 0;
    best_sq    = 0;
    dropped    = 1'b0;
    return 1'b1;
  endfunction

  function automatic int unsigned rand_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [psmpd_pkg::CoordW-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'($urandom_range(0, 64)) - 16'sd32;
      default: return 16'($urandom);
    endcase
  endfunction

  // called at a rising edge, returns at the edge where the request is taken or after a random idle gap behind it
  task automatic send_point(input psmpd_pkg::in_req_t r, input bit typed,
                            input psmpd_pkg::out_rsp_t typed_rsp);
    psmpd_pkg::out_rsp_t rsp;
    int unsigned         gap;
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
    if (diameter_step(r, rsp)) begin
      if (typed) rsp = typed_rsp;
      pending_diameters.insert(pending_diameters.size(), rsp);
    end
    gap = rand_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_diameters.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      if (!calm && $urandom_range(0, 3) == 0) stall_left <= rand_gap();
    end
  end

  always @(posedge clk_i) begin
    psmpd_pkg::out_rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_diameters.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: got %p", out_rsp_o);
      end else begin
        want = pending_diameters.pop_front();
        if (out_rsp_o.max_distance !== want.max_distance ||
            out_rsp_o.points_kept !== want.points_kept ||
            out_rsp_o.overflowed !== want.overflowed) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display({"mismatch at %0t: expected dist %0d kept %0d ovf %0d,",
                      " got dist %0d kept %0d ovf %0d"},
                     $realtime, want.max_distance, want.points_kept, want.overflowed,
                     out_rsp_o.max_distance, out_rsp_o.points_kept, out_rsp_o.overflowed);
          end
        end
      end
    end
  end

  initial begin
    psmpd_pkg::in_req_t r;
    int unsigned        rand_items;
    int unsigned        set_len;
    int unsigned        pick;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    calm        = 1'b0;
    mismatches  = 0;
    kept_count  = 0;
    best_sq     = 0;
    dropped     = 1'b0;
    rand_items  = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int unsigned i = 0; i < NumRows; i++) begin
      r.point_x    = DirRows[i].x;
      r.point_y    = DirRows[i].y;
      r.last_point = DirRows[i].last;
      send_point(r, DirRows[i].typed,
                 '{DirRows[i].max_dist, DirRows[i].kept, DirRows[i].ovf});
    end
    wait_drained();

    // random sets
    while (rand_items < RandItems) begin
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 15) == 0) wait_drained();
      pick = $urandom_range(0, 9);
      if (pick < 6) set_len = $urandom_range(1, 6);
      else if (pick < 9) set_len = $urandom_range(7, 24);
      else set_len = $urandom_range(25, 60);
      rand_items += set_len;
      for (int unsigned i = 0; i < set_len; i++) begin
        r.point_x    = rand_coord();
        r.point_y    = rand_coord();
        r.last_point = (i == set_len - 1);
        send_point(r, 1'b0, '0);
      end
    end

    calm = 1'b0;
    wait_drained();
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0 && pending_diameters.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: point_set_max_planar_distance_top.f
hw/rtl/psmpd_pkg.sv
hw/rtl/psmpd_store.sv
hw/rtl/psmpd_dist.sv
hw/rtl/psmpd_isqrt.sv
hw/rtl/point_set_max_planar_distance_top.sv
dv/point_set_max_planar_distance_top_tb.sv
